FILE: hw/rtl/dss_pkg.sv
// Shared types and constants for the multiplexed segment display scanner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dss_pkg;

	// Command codes carried in the command field.
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_FILL   = 3'd1;
	localparam logic [2:0] CMD_WRITE  = 3'd2;
	localparam logic [2:0] CMD_NUMBER = 3'd3;
	localparam logic [2:0] CMD_TICK   = 3'd4;

	// Status codes returned with every result word.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_IDX  = 2'd1;
	localparam logic [1:0] STAT_BAD_BASE = 2'd2;
	localparam logic [1:0] STAT_TOO_LONG = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_DIGIT_COUNT   = 3'd0;
	localparam logic [2:0] CFG_SEGMENT_COUNT = 3'd1;
	localparam logic [2:0] CFG_COMMON_ANODE  = 3'd2;
	localparam logic [2:0] CFG_FONT_LOW      = 3'd3;
	localparam logic [2:0] CFG_FONT_HIGH     = 3'd4;

	// Accepted radix range for number conversion.
	localparam logic [4:0] BASE_MIN = 5'd2;
	localparam logic [4:0] BASE_MAX = 5'd16;

	// Width of the number operand and of the divider step counter.
	localparam int NUM_W   = 16;
	localparam int STEP_W  = $clog2(NUM_W + 1);

	// Input word.
	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  digit_select;
		logic [15:0] value;
		logic [4:0]  number_base;
	} dss_in_t;

	// Result word.
	typedef struct packed {
		logic [7:0] segment_levels;
		logic [7:0] digit_levels;
		logic [1:0] status;
	} dss_out_t;

	// Control strobes from the sequencer to the pattern memory.
	typedef struct packed {
		logic we;
		logic re;
		logic clr;
	} dss_mem_ctl_t;

	// Pick the segment pattern for one digit value out of the 16-entry font.
	function automatic logic [7:0] font_byte(input logic [127:0] font, input logic [3:0] d);
		font_byte = font[{d, 3'b000} +: 8];
	endfunction

endpackage

FILE: hw/rtl/dss_pattern_mem.sv
// Digit pattern store: one 8-bit segment pattern per digit, synchronous read.
// Depends on dss_pkg for the control struct.
`timescale 1ns / 1ps

module dss_pattern_mem
	import dss_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  dss_mem_ctl_t ctl,
	input  logic [AW-1:0] addr,
	input  logic [7:0]   wdata,
	output logic [7:0]   rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0] rdata_q;

	// Valid bits: a clear drops every entry at once, so unwritten entries read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.we) begin
			valid_q[addr] <= 1'b1;
		end
	end

	// Storage array and registered read port.
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= valid_q[addr] ? mem_q[addr] : 8'h00;
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/dss_divider.sv
// Bit-serial restoring divider: 16-bit dividend by a 5-bit radix, one quotient bit a cycle.
// Depends on dss_pkg for operand widths.
`timescale 1ns / 1ps

module dss_divider
	import dss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [4:0]       divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient,
	output logic [3:0]       remainder
);

	logic [NUM_W-1:0]  quo_q;
	logic [4:0]        rem_q;
	logic [4:0]        div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [5:0]        trial;
	logic              fits;
	logic [5:0]        diff;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// Step counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1));
			if (start) begin
				cnt_q <= STEP_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	// Datapath: the quotient builds up in place of the dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[4:0] : trial[4:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[3:0];

endmodule

FILE: hw/rtl/dss_ctrl.sv
// Command sequencer: scan state, drive levels, number conversion and the result register.
// Depends on dss_pkg; drives dss_pattern_mem and dss_divider from the top level.
`timescale 1ns / 1ps

module dss_ctrl
	import dss_pkg::*;
#(
	parameter int MAX_DIGITS = 8,
	parameter int DW         = 3,
	parameter int CW         = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  dss_in_t          cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output dss_out_t         res,
	input  logic [CW-1:0]    n_use,
	input  logic [7:0]       seg_mask,
	input  logic             anode,
	input  logic [127:0]     font,
	output dss_mem_ctl_t     mem_ctl,
	output logic [DW-1:0]    mem_addr,
	output logic [7:0]       mem_wdata,
	input  logic [7:0]       mem_rdata,
	output logic             div_start,
	output logic [NUM_W-1:0] div_num,
	output logic [4:0]       div_base,
	input  logic             div_done,
	input  logic [NUM_W-1:0] div_quo,
	input  logic [3:0]       div_rem
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_FILL     = 7'b0000010,
		ST_NUM_DIV  = 7'b0000100,
		ST_NUM_WR   = 7'b0001000,
		ST_TICK_RD  = 7'b0010000,
		ST_TICK_WRAP = 7'b0100000,
		ST_FINISH   = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [7:0]           val_q;
	logic [4:0]           base_q;
	logic [1:0]           status_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        wrap_q;
	logic [3:0]           digit_buf_q [MAX_DIGITS];
	logic [DW-1:0]        pos_q;
	logic                 phase_q;
	logic [7:0]           seg_q;
	logic [MAX_DIGITS-1:0] dig_q;
	dss_out_t             res_q;
	logic                 res_valid_q;

	logic                 acc;
	logic                 sel_bad;
	logic                 base_bad;
	logic                 last_digit;
	logic                 slot_free;
	logic [MAX_DIGITS+7:0] dig_pad;

	assign acc        = cmd_valid && !cmd_stall && (state_q == ST_IDLE);
	assign cmd_stall  = (state_q != ST_IDLE);
	assign sel_bad    = {2'b00, cmd.digit_select} >= 5'(n_use);
	assign base_bad   = (cmd.number_base < BASE_MIN) || (cmd.number_base > BASE_MAX);
	assign last_digit = (k_q + CW'(1)) == n_use;
	assign slot_free  = !res_valid_q || !res_stall;
	assign dig_pad    = {8'h00, dig_q};

	// Memory and divider requests for the current state.
	always_comb begin
		mem_ctl   = '0;
		mem_addr  = pos_q;
		mem_wdata = val_q;
		div_start = 1'b0;
		div_num   = div_quo;
		div_base  = base_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd.command)
						CMD_CLEAR: mem_ctl.clr = 1'b1;
						CMD_WRITE: begin
							mem_ctl.we = !sel_bad;
							mem_addr   = DW'(cmd.digit_select);
							mem_wdata  = cmd.value[7:0];
						end
						CMD_NUMBER: begin
							div_start = !base_bad;
							div_num   = cmd.value;
							div_base  = cmd.number_base;
						end
						CMD_TICK: mem_ctl.re = phase_q;
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				mem_ctl.we = 1'b1;
				mem_addr   = idx_q[DW-1:0];
			end
			ST_NUM_DIV: begin
				div_start = div_done && (div_quo != '0) && !last_digit;
			end
			ST_NUM_WR: begin
				mem_ctl.we = 1'b1;
				mem_addr   = idx_q[DW-1:0];
				mem_wdata  = (idx_q < k_q) ? font_byte(font, digit_buf_q[idx_q[DW-1:0]]) : 8'h00;
			end
			default: ;
		endcase
	end

	// Sequencer and scan state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			phase_q     <= 1'b1;
			seg_q       <= '0;
			dig_q       <= '1;
			res_valid_q <= 1'b0;
		end else begin
			// The result register fills when an item finishes and empties when taken.
			if ((state_q == ST_FINISH) && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (cmd.command)
							CMD_CLEAR: begin
								pos_q   <= '0;
								phase_q <= 1'b1;
								state_q <= ST_FINISH;
							end
							CMD_FILL: state_q <= ST_FILL;
							CMD_NUMBER: begin
								if (!base_bad) begin
									state_q <= ST_NUM_DIV;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							CMD_TICK: begin
								if (phase_q) begin
									state_q <= ST_TICK_RD;
								end else begin
									// Darken the current digit, then wrap the position.
									dig_q[pos_q] <= !anode;
									phase_q      <= 1'b1;
									state_q      <= ST_TICK_WRAP;
								end
							end
							default: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_FILL: begin
					if ((idx_q + CW'(1)) == n_use) begin
						state_q <= ST_FINISH;
					end
				end
				ST_NUM_DIV: begin
					if (div_done) begin
						if (div_quo == '0) begin
							state_q <= ST_NUM_WR;
						end else if (last_digit) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_NUM_WR: begin
					if ((idx_q + CW'(1)) == n_use) begin
						state_q <= ST_FINISH;
					end
				end
				ST_TICK_RD: begin
					// Light the current digit with its pattern on the segment lines in use.
					seg_q        <= (seg_q & ~seg_mask) | ((mem_rdata ^ {8{anode}}) & seg_mask);
					dig_q[pos_q] <= anode;
					phase_q      <= 1'b0;
					state_q      <= ST_FINISH;
				end
				ST_TICK_WRAP: begin
					if (wrap_q < n_use) begin
						pos_q   <= DW'(wrap_q);
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload, counters and the converted digit buffer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q  <= '0;
				k_q    <= '0;
				val_q  <= cmd.value[7:0];
				base_q <= cmd.number_base;
				wrap_q <= CW'(pos_q) + CW'(1);
				if (acc) begin
					if ((cmd.command == CMD_WRITE) && sel_bad) begin
						status_q <= STAT_BAD_IDX;
					end else if ((cmd.command == CMD_NUMBER) && base_bad) begin
						status_q <= STAT_BAD_BASE;
					end else begin
						status_q <= STAT_OK;
					end
				end
			end
			ST_FILL, ST_NUM_WR: idx_q <= idx_q + CW'(1);
			ST_NUM_DIV: begin
				if (div_done) begin
					digit_buf_q[k_q[DW-1:0]] <= div_rem;
					k_q <= k_q + CW'(1);
					if ((div_quo != '0) && last_digit) begin
						status_q <= STAT_TOO_LONG;
					end
				end
			end
			ST_TICK_WRAP: begin
				if (wrap_q >= n_use) begin
					wrap_q <= wrap_q - n_use;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					res_q.segment_levels <= seg_q;
					res_q.digit_levels   <= dig_pad[7:0];
					res_q.status         <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// The scan position always names a physical digit.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < MAX_DIGITS)
		else $error("scan position beyond the digit array");

	// A rejected radix finishes at once with the bad-base status.
	a_bad_base: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd.command == CMD_NUMBER) && base_bad) |=>
		(state_q == ST_FINISH) && (status_q == STAT_BAD_BASE))
		else $error("bad radix not reported");

	// Every lighting step flips the phase.
	a_phase_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK_RD) |=> (phase_q != $past(phase_q)))
		else $error("lighting phase did not toggle");

	// Conversion never holds more digits than are in use.
	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NUM_DIV) |-> (k_q < n_use))
		else $error("converted digit count exceeds digits in use");

	// The memory is never written outside a command that updates patterns.
	a_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.we |-> ((state_q == ST_FILL) || (state_q == ST_NUM_WR) ||
		(acc && (cmd.command == CMD_WRITE))))
		else $error("unexpected pattern write");
`endif

endmodule

FILE: hw/rtl/multiplexed_segment_display_scanner.sv
// Multiplexed segment display scanner: one command word in, one result word out.
// Takes one word at a time; a finished result waits in an output register while the
// next command is already accepted. A darkening tick also wraps the scan position by
// subtracting the digit count, and fill writes a pattern to each digit in use. Write
// number runs the bit-serial divider once for each base digit it produces, then
// writes the patterns back to the digit pattern memory, which has one port and a
// registered read, and then delivers the result. A stalled output holds the next
// result back until the output register is free.
// Depends on dss_pkg, dss_pattern_mem, dss_divider and dss_ctrl.
`timescale 1ns / 1ps

module multiplexed_segment_display_scanner
	import dss_pkg::*;
#(
	parameter int MAX_DIGITS   = 8,
	parameter int MAX_SEGMENTS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  dss_in_t  cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output dss_out_t res
);

	localparam int DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam logic [4:0] MAXD = 5'(MAX_DIGITS);
	localparam logic [3:0] MAXS = 4'(MAX_SEGMENTS);

	logic [3:0]   digit_count_q;
	logic [3:0]   segment_count_q;
	logic         common_anode_q;
	logic [63:0]  font_low_q;
	logic [63:0]  font_high_q;

	logic [4:0]   dc5;
	logic [4:0]   n5;
	logic [3:0]   ns;
	logic [CW-1:0] n_use;
	logic [7:0]   seg_mask;

	dss_mem_ctl_t     mem_ctl;
	logic [DW-1:0]    mem_addr;
	logic [7:0]       mem_wdata;
	logic [7:0]       mem_rdata;
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [4:0]       div_base;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;
	logic [3:0]       div_rem;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q   <= 4'd8;
			segment_count_q <= 4'd8;
			common_anode_q  <= 1'b0;
			font_low_q      <= '0;
			font_high_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIGIT_COUNT:   digit_count_q   <= cfg_data[3:0];
				CFG_SEGMENT_COUNT: segment_count_q <= cfg_data[3:0];
				CFG_COMMON_ANODE:  common_anode_q  <= cfg_data[0];
				CFG_FONT_LOW:      font_low_q      <= cfg_data;
				CFG_FONT_HIGH:     font_high_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the counts into the ranges the hardware supports.
	always_comb begin
		dc5 = {1'b0, digit_count_q};
		if (dc5 == 5'd0) begin
			n5 = 5'd1;
		end else if (dc5 > MAXD) begin
			n5 = MAXD;
		end else begin
			n5 = dc5;
		end
		n_use = CW'(n5);

		if (segment_count_q == 4'd0) begin
			ns = 4'd1;
		end else if (segment_count_q > MAXS) begin
			ns = MAXS;
		end else begin
			ns = segment_count_q;
		end
		for (int s = 0; s < 8; s++) begin
			seg_mask[s] = 4'(s) < ns;
		end
	end

	dss_pattern_mem #(
		.DEPTH (MAX_DIGITS),
		.AW    (DW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	dss_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_base),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	dss_ctrl #(
		.MAX_DIGITS (MAX_DIGITS),
		.DW         (DW),
		.CW         (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.n_use     (n_use),
		.seg_mask  (seg_mask),
		.anode     (common_anode_q),
		.font      ({font_high_q, font_low_q}),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.div_start (div_start),
		.div_num   (div_num),
		.div_base  (div_base),
		.div_done  (div_done),
		.div_quo   (div_quo),
		.div_rem   (div_rem)
	);

endmodule
